FILE: src/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int OFS_OUT_W  = 32;
    localparam int MASK_W     = 16;
    localparam int LEN_W      = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO = 2'd0,
        CFG_PAT_HI = 2'd1,
        CFG_WILD   = 2'd2,
        CFG_LEN    = 2'd3
    } t_cfg_idx;

endpackage

FILE: src/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner: finds the first match of a masked byte pattern per region.
//
// Takes one byte per cycle on the slave stream (tlast closes a region) and
// reports at most one result per region on the master stream: tuser = 1 with
// the start offset of the first match, or tuser = 0 with offset 0 when the
// region ends without a match. Config requests are always accepted (o_cfg_ready
// is tied high); the result of a taken byte appears in the output register on
// the next cycle, and a new byte is taken every cycle unless that output
// register holds an untaken result. Pattern (up to MAX_PATTERN entries), wildcard
// mask and length must be written through the config port only while the stream
// is idle; the block does not enforce this. Length 0 acts as 1, lengths above
// MAX_PATTERN act as MAX_PATTERN. The byte counter is OFFSET_BITS wide and saturates.
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wbps_pkg::t_cfg_idx                     i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // byte stream in
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [wbps_pkg::BYTE_W-1:0]            i_s_axis_tdata,  // [7:0] data_byte
    input  logic                                   i_s_axis_tlast,  // region_last
    // result stream out
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [wbps_pkg::OFS_OUT_W-1:0]         o_m_axis_tdata,  // [31:0] match_offset
    output logic                                   o_m_axis_tuser   // match_found
);
    import wbps_pkg::*;

    localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [CFG_DATA_W-1:0]     r_pat_lo;
    logic [CFG_DATA_W-1:0]     r_pat_hi;
    logic [MASK_W-1:0]         r_wild;
    logic [LEN_W-1:0]          r_len;

    logic [BYTE_W-1:0]         r_win [MAX_PATTERN];
    logic [BYTE_W-1:0]         n_win [MAX_PATTERN];
    logic [OFFSET_BITS-1:0]    r_seen;
    logic [OFFSET_BITS-1:0]    n_seen;
    logic                      r_found;

    logic                      r_out_valid;
    logic                      r_out_found;
    logic [OFS_OUT_W-1:0]      r_out_ofs;

    logic                      n_res_valid;
    logic                      n_res_found;
    logic [OFS_OUT_W-1:0]      n_res_ofs;

    logic [2*CFG_DATA_W-1:0]   pat;
    logic [LEN_W-1:0]          ulen;
    logic                      win_hit;
    logic                      s_acc;
    logic [OFFSET_BITS-1:0]    ofs_full;

    assign o_cfg_ready     = 1'b1;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_ofs;
    assign o_m_axis_tuser  = r_out_found;
    assign pat             = {r_pat_hi, r_pat_lo};

    always_comb begin
        if (r_len == '0) begin
            ulen = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            ulen = LEN_W'(MAX_PATTERN);
        end else begin
            ulen = r_len;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
            n_win[j] = r_win[j+1];
        end
        n_win[MAX_PATTERN-1] = i_s_axis_tdata;
    end

    // masked compare of the newest ulen bytes against pattern entries
    always_comb begin
        logic [5:0] idx;
        win_hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            idx = 6'(MAX_PATTERN) - 6'(ulen) + 6'(k);
            if ((k < int'(ulen)) && !r_wild[k] &&
                (n_win[idx[IdxW-1:0]] != pat[8*k +: 8])) begin
                win_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_seen      = (r_seen != '1) ? r_seen + OFFSET_BITS'(1) : r_seen;
        ofs_full    = n_seen - OFFSET_BITS'(ulen);
        n_res_valid = 1'b0;
        n_res_found = 1'b0;
        n_res_ofs   = '0;
        if (!r_found && (n_seen >= OFFSET_BITS'(ulen)) && win_hit) begin
            n_res_valid = 1'b1;
            n_res_found = 1'b1;
            n_res_ofs   = OFS_OUT_W'(ofs_full);
        end else if (!r_found && i_s_axis_tlast) begin
            n_res_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAT_LO: r_pat_lo <= i_cfg_data;
                CFG_PAT_HI: r_pat_hi <= i_cfg_data;
                CFG_WILD:   r_wild   <= i_cfg_data[MASK_W-1:0];
                CFG_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_out_valid <= n_res_valid;
                if (i_s_axis_tlast) begin
                    r_seen  <= '0;
                    r_found <= 1'b0;
                end else begin
                    r_seen  <= n_seen;
                    r_found <= r_found || n_res_found;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window needs no reset: the byte count gates every compare
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_win       <= n_win;
            r_out_found <= n_res_found;
            r_out_ofs   <= n_res_ofs;
        end
    end

    a_region_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tlast) |=> (r_seen == '0) && !r_found)
        else $error("scan state not cleared after region end");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("not-found result carries nonzero offset");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_found) |-> !n_res_valid)
        else $error("second result in one region");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while result stalled");

endmodule
